### hdl/encoder_angle_pll_tracker_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the encoder angle PLL tracker
// Shared property templates clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ENCODER_ANGLE_PLL_TRACKER_MACROS_SVH
`define ENCODER_ANGLE_PLL_TRACKER_MACROS_SVH

// Overlapping implication: the consequent is checked in the same cycle.
`define EAPT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication: the consequent starts in the next cycle.
`define EAPT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/eapt_pkg.sv
// ----------------------------------------------------------------------------
// Encoder angle PLL tracker package
// Payload types, register indexes, datapath control words and the microcode.
// ----------------------------------------------------------------------------
package eapt_pkg;

    localparam int COUNT_BITS_DEFAULT = 12;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLE_PAIRS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_SCALE  = 2'd3;

    localparam logic [5:0] POLE_PAIRS_RESET = 6'd7;

    typedef struct packed {
        logic       sample_valid;
        logic [7:0] rx_high;
        logic [7:0] rx_low;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        pll_angle;
        logic [15:0]        measured_angle;
        logic signed [15:0] speed_rpm;
    } out_item_t;

    // Multiplier operand selects.
    localparam logic [1:0] A_MECH  = 2'd0;
    localparam logic [1:0] A_ERR   = 2'd1;
    localparam logic [1:0] A_SPEED = 2'd2;

    localparam logic [1:0] B_POLE  = 2'd0;
    localparam logic [1:0] B_KI    = 2'd1;
    localparam logic [1:0] B_KP    = 2'd2;
    localparam logic [1:0] B_RPM   = 2'd3;

    typedef struct packed {
        logic       ld_in;
        logic       mul_en;
        logic [1:0] a_sel;
        logic [1:0] b_sel;
        logic       ld_meas;
        logic       ld_speed;
        logic       ld_phase;
    } dp_ctrl_t;

    typedef struct packed {
        dp_ctrl_t dp;
        logic     wait_in;
        logic     wait_out;
        logic     ld_out;
    } ucode_t;

    localparam int STEP_W = 3;

    localparam logic [STEP_W-1:0] STEP_IDLE     = 3'd0;
    localparam logic [STEP_W-1:0] STEP_MEAS_MUL = 3'd1;
    localparam logic [STEP_W-1:0] STEP_MEAS     = 3'd2;
    localparam logic [STEP_W-1:0] STEP_KI_MUL   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_SPEED    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_KP_MUL   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_PHASE    = 3'd6;
    localparam logic [STEP_W-1:0] STEP_OUT      = 3'd7;

    // Program ROM: one control word per step. The last step wraps to idle.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '0;
        unique case (step)
            STEP_IDLE:     w.wait_in = 1'b1;
            STEP_MEAS_MUL:
            begin
                w.dp.mul_en = 1'b1;
                w.dp.a_sel  = A_MECH;
                w.dp.b_sel  = B_POLE;
            end
            STEP_MEAS:     w.dp.ld_meas = 1'b1;
            STEP_KI_MUL:
            begin
                w.dp.mul_en = 1'b1;
                w.dp.a_sel  = A_ERR;
                w.dp.b_sel  = B_KI;
            end
            STEP_SPEED:    w.dp.ld_speed = 1'b1;
            STEP_KP_MUL:
            begin
                w.dp.mul_en = 1'b1;
                w.dp.a_sel  = A_ERR;
                w.dp.b_sel  = B_KP;
            end
            STEP_PHASE:
            begin
                w.dp.ld_phase = 1'b1;
                w.dp.mul_en   = 1'b1;
                w.dp.a_sel    = A_SPEED;
                w.dp.b_sel    = B_RPM;
            end
            STEP_OUT:
            begin
                w.ld_out   = 1'b1;
                w.wait_out = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

### hdl/eapt_datapath.sv
// ----------------------------------------------------------------------------
// Encoder angle PLL tracker datapath
// Shared multiplier, loop state and adders driven by microcode; speed and RPM saturate.
// ----------------------------------------------------------------------------
module eapt_datapath #(
    parameter int COUNT_BITS = eapt_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  eapt_pkg::dp_ctrl_t  ctrl,
    input  eapt_pkg::in_item_t  in_data,
    input  logic [15:0]         kp_gain,
    input  logic [15:0]         ki_gain,
    input  logic [5:0]          pole_pairs,
    input  logic [19:0]         rpm_scale,
    output eapt_pkg::out_item_t result
);
    import eapt_pkg::*;

    localparam int SHIFT = 16 - COUNT_BITS;

    logic                  sv_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [15:0]           meas_reg;
    logic [15:0]           meas_next;
    logic [15:0]           phase_reg;
    logic [15:0]           phase_next;
    logic signed [31:0]    speed_reg;
    logic signed [31:0]    speed_next;
    logic signed [53:0]    prod_reg;

    logic [15:0]           raw;
    logic [16:0]           mech;
    logic signed [15:0]    err;
    logic signed [32:0]    mul_a;
    logic signed [20:0]    mul_b;
    logic signed [53:0]    prod;
    logic signed [33:0]    speed_sum;
    logic [31:0]           phase_sum;
    logic signed [21:0]    rpm_full;
    logic signed [15:0]    rpm_sat;

    assign raw  = {in_data.rx_high, in_data.rx_low};
    // Reversed count: a zero count becomes a full turn and wraps to zero.
    assign mech = (17'(1 << COUNT_BITS) - 17'(count_reg)) << SHIFT;
    assign err  = signed'(meas_reg - phase_reg);

    always_comb
    begin
        unique case (ctrl.a_sel)
            A_MECH:  mul_a = signed'({16'd0, mech});
            A_ERR:   mul_a = 33'(err);
            A_SPEED: mul_a = 33'(speed_reg);
            default: mul_a = '0;
        endcase
        unique case (ctrl.b_sel)
            B_POLE:  mul_b = signed'({15'd0, pole_pairs});
            B_KI:    mul_b = signed'({5'd0, ki_gain});
            B_KP:    mul_b = signed'({5'd0, kp_gain});
            B_RPM:   mul_b = signed'({1'b0, rpm_scale});
            default: mul_b = '0;
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        if (sv_reg)
        begin
            meas_next = prod_reg[15:0];
        end
        else
        begin
            meas_next = phase_reg + speed_reg[31:16];
        end
    end

    // Integrator with saturation at the 32-bit signed limits.
    assign speed_sum = 34'(speed_reg) + prod_reg[33:0];
    always_comb
    begin
        if (speed_sum[33:31] == 3'b000 || speed_sum[33:31] == 3'b111)
        begin
            speed_next = speed_sum[31:0];
        end
        else if (speed_sum[33])
        begin
            speed_next = 32'sh8000_0000;
        end
        else
        begin
            speed_next = 32'sh7FFF_FFFF;
        end
    end

    assign phase_sum  = speed_reg + prod_reg[31:0];
    assign phase_next = phase_reg + phase_sum[31:16];

    assign rpm_full = prod_reg[53:32];
    always_comb
    begin
        if (rpm_full[21:15] == 7'h00 || rpm_full[21:15] == 7'h7F)
        begin
            rpm_sat = rpm_full[15:0];
        end
        else if (rpm_full[21])
        begin
            rpm_sat = 16'sh8000;
        end
        else
        begin
            rpm_sat = 16'sh7FFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            speed_reg <= '0;
        end
        else
        begin
            if (ctrl.ld_speed)
            begin
                speed_reg <= speed_next;
            end
            if (ctrl.ld_phase)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_in)
        begin
            sv_reg    <= in_data.sample_valid;
            count_reg <= raw[COUNT_BITS-1:0];
        end
        if (ctrl.ld_meas)
        begin
            meas_reg <= meas_next;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod;
        end
    end

    assign result.pll_angle      = phase_reg;
    assign result.measured_angle = meas_reg;
    assign result.speed_rpm      = rpm_sat;

endmodule

### hdl/encoder_angle_pll_tracker.sv
// ----------------------------------------------------------------------------
// Encoder angle PLL tracker
// Microcoded PI phase-locked loop that tracks the electrical rotor angle.
// ----------------------------------------------------------------------------
// Each input item runs through the eight-step program, which shares one
// multiplier, so a new item is taken only once the previous one has passed
// every step; the last step holds while the previous result is not taken.
// Reset clears the phase and speed estimates and the gains, sets pole pairs
// to 7, and returns the step counter to idle.
module encoder_angle_pll_tracker #(
    parameter int COUNT_BITS = eapt_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  eapt_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output eapt_pkg::out_item_t                 out_data,
    input  logic                                cfg_write,
    input  logic [eapt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [eapt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import eapt_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [15:0]       kp_reg;
    logic [15:0]       ki_reg;
    logic [5:0]        pole_reg;
    logic [19:0]       rpm_scale_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_data_reg;

    ucode_t            uc;
    dp_ctrl_t          dp_ctrl;
    out_item_t         result;
    logic              accept;
    logic              out_blocked;
    logic              out_load;

    assign uc          = ucode_rom(step_reg);
    assign in_ready    = uc.wait_in;
    assign accept      = in_valid && in_ready;
    assign out_blocked = out_valid_reg && !out_ready;
    assign out_load    = uc.ld_out && !out_blocked;

    always_comb
    begin
        dp_ctrl       = uc.dp;
        dp_ctrl.ld_in = accept;
    end

    // The step counter holds on a waiting step until its condition is met.
    always_comb
    begin
        priority if (uc.wait_in && !accept)
        begin
            step_next = step_reg;
        end
        else if (uc.wait_out && out_blocked)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_comb
    begin
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            out_valid_reg <= 1'b0;
            kp_reg        <= '0;
            ki_reg        <= '0;
            pole_reg      <= POLE_PAIRS_RESET;
            rpm_scale_reg <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_KP_GAIN:    kp_reg        <= cfg_data[15:0];
                    REG_KI_GAIN:    ki_reg        <= cfg_data[15:0];
                    REG_POLE_PAIRS: pole_reg      <= cfg_data[5:0];
                    REG_RPM_SCALE:  rpm_scale_reg <= cfg_data[19:0];
                    default:        kp_reg        <= kp_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= result;
        end
    end

    eapt_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (dp_ctrl),
        .in_data    (in_data),
        .kp_gain    (kp_reg),
        .ki_gain    (ki_reg),
        .pole_pairs (pole_reg),
        .rpm_scale  (rpm_scale_reg),
        .result     (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hdl/eapt_checker.sv
// ----------------------------------------------------------------------------
// Encoder angle PLL tracker checker
// Port-level properties on handshake timing, bound to the top level.
// ----------------------------------------------------------------------------
`include "encoder_angle_pll_tracker_macros.svh"

module eapt_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input eapt_pkg::out_item_t  out_data
);
    import eapt_pkg::*;

    // A stalled result stays and holds its value.
    `EAPT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

    // After a transaction the program runs seven busy steps before it can take another.
    `EAPT_ASSERT_NXT(a_busy_window, in_valid && in_ready, !in_ready [*7], "input taken during a busy step")

    // A fresh result rises only after its input transaction has passed every program step.
    `EAPT_ASSERT_IMP(a_result_timing, $rose(out_valid), $past(in_valid && in_ready, 8), "result without matching input transaction")

endmodule

bind encoder_angle_pll_tracker eapt_checker u_eapt_checker (.*);

### verif/tb_encoder_angle_pll_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the encoder angle PLL tracker
// Drives encoder ticks through the valid/ready input channel, predicts each
// result with a bit-accurate PLL model that tracks the register writes or from
// a directed row, and compares each result field by field. Directed ticks run
// first, then random phases of tracking trajectories and noise.
// ----------------------------------------------------------------------------
module tb_encoder_angle_pll_tracker;

    import eapt_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int COUNT_BITS     = COUNT_BITS_DEFAULT;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_TICKS    = 215;
    localparam int PRESSURE_PHASE = 3;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam longint INT32_HI = 64'sd2147483647;
    localparam longint INT32_LO = -64'sd2147483648;

    typedef enum logic { ROW_TICK, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_DATA_W-1:0]      val;
        in_item_t                   tick;
        bit                         typed;
        out_item_t                  want;
    } dir_row_t;

    typedef struct {
        bit        typed;
        out_item_t want;
    } tick_tag_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Model copy of the registers and the loop state.
    logic [15:0] kp_q;
    logic [15:0] ki_q;
    logic [5:0]  pole_q;
    logic [19:0] rpm_q;
    logic [15:0] phase_q;
    int          speed_q;

    out_item_t predicted_results[$];
    tick_tag_t offered_tags[$];
    dir_row_t  directed_rows[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    bit        calm = 1'b0;
    bit        hold_req = 1'b0;

    encoder_angle_pll_tracker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // One control tick of the PLL: measured or predicted angle, PI update.
    function automatic out_item_t track_tick(in_item_t it);
        logic [15:0]        raw;
        logic [31:0]        count_v;
        logic [31:0]        mech;
        logic [31:0]        scaled;
        logic [15:0]        meas;
        logic [15:0]        diff;
        logic signed [15:0] err;
        longint             acc;
        out_item_t          r;
        if (it.sample_valid)
        begin
            raw     = {it.rx_high, it.rx_low};
            count_v = 32'(raw) & ((32'd1 << COUNT_BITS) - 32'd1);
            // A zero count reverses to a full turn, which wraps to zero below.
            mech    = ((32'd1 << COUNT_BITS) - count_v) << (16 - COUNT_BITS);
            scaled  = mech * 32'(pole_q);
            meas    = scaled[15:0];
        end
        else
        begin
            meas = phase_q + 16'(speed_q >>> 16);
        end
        diff = meas - phase_q;
        err  = signed'(diff);
        acc  = longint'(speed_q) + longint'(ki_q) * longint'(err);
        if (acc > INT32_HI)
            acc = INT32_HI;
        else if (acc < INT32_LO)
            acc = INT32_LO;
        speed_q = int'(acc);
        acc     = longint'(speed_q) + longint'(kp_q) * longint'(err);
        phase_q = phase_q + 16'(acc >>> 16);
        acc     = (longint'(speed_q) * longint'(rpm_q)) >>> 32;
        if (acc > 64'sd32767)
            acc = 64'sd32767;
        else if (acc < -64'sd32768)
            acc = -64'sd32768;
        r.pll_angle      = phase_q;
        r.measured_angle = meas;
        r.speed_rpm      = 16'(acc);
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic dir_row_t fixed_row(bit sv, logic [7:0] hi, logic [7:0] lo,
                                           logic [15:0] pll, logic [15:0] meas,
                                           logic [15:0] rpm);
        dir_row_t row;
        row.kind  = ROW_TICK;
        row.idx   = '0;
        row.val   = '0;
        row.tick  = '{sample_valid: sv, rx_high: hi, rx_low: lo};
        row.typed = 1'b1;
        row.want  = '{pll_angle: pll, measured_angle: meas, speed_rpm: rpm};
        return row;
    endfunction

    function automatic dir_row_t pred_row(bit sv, logic [7:0] hi, logic [7:0] lo);
        dir_row_t row;
        row       = fixed_row(sv, hi, lo, 16'd0, 16'd0, 16'd0);
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row      = pred_row(1'b0, 8'd0, 8'd0);
        row.kind = ROW_REG;
        row.idx  = idx;
        row.val  = val;
        return row;
    endfunction

    // Result check, tick prediction and register tracking at each rising edge.
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        out_item_t got;
        tick_tag_t tag;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: result with no tick pending, expected none actual %p",
                             $time, out_data);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("pll_angle", int'(want.pll_angle), int'(out_data.pll_angle));
                    check_field("measured_angle", int'(want.measured_angle),
                                int'(out_data.measured_angle));
                    check_field("speed_rpm", int'(want.speed_rpm), int'(out_data.speed_rpm));
                end
            end
            if (in_valid && in_ready)
            begin
                tag = offered_tags.pop_front();
                got = track_tick(in_data);
                if (tag.typed)
                    got = tag.want;
                predicted_results.push_back(got);
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_KP_GAIN:    kp_q   = cfg_data[15:0];
                    REG_KI_GAIN:    ki_q   = cfg_data[15:0];
                    REG_POLE_PAIRS: pole_q = cfg_data[5:0];
                    REG_RPM_SCALE:  rpm_q  = cfg_data[19:0];
                    default: ;
                endcase
            end
        end
    end

    // Watchdog on cycles without any transaction or register write.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: random stalls, one long hold-off on request, none when calm.
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_tick(in_item_t it, bit typed, out_item_t want);
        tick_tag_t tag;
        tag.typed = typed;
        tag.want  = want;
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        offered_tags.push_back(tag);
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Registers change only once the block has returned every result.
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_results.size() != 0 || offered_tags.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin : main
        dir_row_t    row;
        in_item_t    it;
        out_item_t   none;
        logic [11:0] pos;
        int          vel;
        int          pick;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        kp_q      = '0;
        ki_q      = '0;
        pole_q    = POLE_PAIRS_RESET;
        rpm_q     = '0;
        phase_q   = '0;
        speed_q   = 0;
        none      = '0;

        // Reset defaults: zero gains and scale, seven pole pairs.
        directed_rows.push_back(fixed_row(1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000));
        directed_rows.push_back(fixed_row(1'b1, 8'h08, 8'h00, 16'h0000, 16'h8000, 16'h0000));
        directed_rows.push_back(fixed_row(1'b1, 8'hFF, 8'hFF, 16'h0000, 16'h0070, 16'h0000));
        directed_rows.push_back(fixed_row(1'b1, 8'h0F, 8'hFF, 16'h0000, 16'h0070, 16'h0000));
        directed_rows.push_back(fixed_row(1'b0, 8'hAA, 8'h55, 16'h0000, 16'h0000, 16'h0000));
        directed_rows.push_back(fixed_row(1'b1, 8'hF0, 8'h00, 16'h0000, 16'h0000, 16'h0000));
        // With no pole pairs every measured angle is zero.
        directed_rows.push_back(reg_row(REG_POLE_PAIRS, 20'd0));
        directed_rows.push_back(fixed_row(1'b1, 8'h03, 8'h21, 16'h0000, 16'h0000, 16'h0000));
        directed_rows.push_back(fixed_row(1'b1, 8'h7C, 8'hDE, 16'h0000, 16'h0000, 16'h0000));
        // Largest gains and RPM scale drive the integrator into saturation.
        directed_rows.push_back(reg_row(REG_KP_GAIN, 20'h0FFFF));
        directed_rows.push_back(reg_row(REG_KI_GAIN, 20'h0FFFF));
        directed_rows.push_back(reg_row(REG_POLE_PAIRS, 20'd32));
        directed_rows.push_back(reg_row(REG_RPM_SCALE, 20'hFFFFF));
        directed_rows.push_back(pred_row(1'b1, 8'h08, 8'h00));
        directed_rows.push_back(pred_row(1'b1, 8'h08, 8'h00));
        directed_rows.push_back(pred_row(1'b1, 8'h0C, 8'h00));
        directed_rows.push_back(pred_row(1'b0, 8'h12, 8'h34));
        directed_rows.push_back(pred_row(1'b0, 8'hFF, 8'h00));
        directed_rows.push_back(pred_row(1'b1, 8'h04, 8'h00));
        directed_rows.push_back(pred_row(1'b1, 8'h00, 8'h01));
        directed_rows.push_back(pred_row(1'b1, 8'hFF, 8'hFF));
        directed_rows.push_back(reg_row(REG_KP_GAIN, 20'd0));
        directed_rows.push_back(reg_row(REG_KI_GAIN, 20'd1));
        directed_rows.push_back(reg_row(REG_POLE_PAIRS, 20'd1));
        directed_rows.push_back(reg_row(REG_RPM_SCALE, 20'd1));
        directed_rows.push_back(pred_row(1'b1, 8'h00, 8'h00));
        directed_rows.push_back(pred_row(1'b1, 8'h08, 8'h01));
        directed_rows.push_back(pred_row(1'b1, 8'h07, 8'hFF));
        directed_rows.push_back(pred_row(1'b0, 8'h5A, 8'hA5));
        directed_rows.push_back(pred_row(1'b1, 8'h0A, 8'hBC));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.kind == ROW_REG)
            begin
                drain_block();
                write_reg(row.idx, row.val);
            end
            else
                send_tick(row.tick, row.typed, row.want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_block();
            calm = (p == NUM_PHASES - 1);
            case (p)
                0:
                begin
                    write_reg(REG_KP_GAIN, 20'h0FFFF);
                    write_reg(REG_KI_GAIN, 20'h0FFFF);
                    write_reg(REG_POLE_PAIRS, 20'd32);
                    write_reg(REG_RPM_SCALE, 20'hFFFFF);
                end
                1:
                begin
                    write_reg(REG_KP_GAIN, 20'd0);
                    write_reg(REG_KI_GAIN, 20'd0);
                    write_reg(REG_POLE_PAIRS, 20'd1);
                    write_reg(REG_RPM_SCALE, 20'd0);
                end
                2:
                begin
                    // Full-width data checks that unused register bits are dropped.
                    write_reg(REG_KP_GAIN, CFG_DATA_W'($urandom));
                    write_reg(REG_KI_GAIN, CFG_DATA_W'($urandom));
                    write_reg(REG_POLE_PAIRS, CFG_DATA_W'($urandom));
                    write_reg(REG_RPM_SCALE, CFG_DATA_W'($urandom));
                end
                default:
                begin
                    write_reg(REG_KP_GAIN, CFG_DATA_W'($urandom_range(16'h1000, 16'h8000)));
                    write_reg(REG_KI_GAIN, CFG_DATA_W'($urandom_range(0, 16'h0400)));
                    write_reg(REG_POLE_PAIRS, CFG_DATA_W'($urandom_range(1, 32)));
                    write_reg(REG_RPM_SCALE, CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
                end
            endcase
            if (p == PRESSURE_PHASE)
                hold_req = 1'b1;

            pos = 12'($urandom);
            vel = $urandom_range(0, 128) - 64;
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if ($urandom_range(0, 31) == 0)
                    vel = $urandom_range(0, 128) - 64;
                pos  = pos + 12'(vel);
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    it = in_item_t'($urandom);
                else if (pick == 1)
                begin
                    // Encoder busy: the block predicts from its own estimates.
                    it = in_item_t'($urandom);
                    it.sample_valid = 1'b0;
                end
                else
                begin
                    it.sample_valid = 1'b1;
                    it.rx_high      = {4'($urandom), pos[11:8]};
                    it.rx_low       = pos[7:0];
                end
                send_tick(it, 1'b0, none);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
